// ===== hdl/cmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cmfs_pkg: shared types and constants of the color memory LCD serializer
// Command codes, register indexes, queue depths and the item and result types.
// ----------------------------------------------------------------------------
package cmfs_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 128;
  localparam int DISPLAY_HEIGHT_DEF = 128;

  // Widest panel allowed; sets the width of the byte column inside a line.
  localparam int WIDTH_MAX = 160;
  localparam int COL_W     = $clog2((3 * WIDTH_MAX + 7) / 8);

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CMD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_CMD = 4'd1;

  localparam logic [2:0] CMD_DRAW  = 3'd0;
  localparam logic [2:0] CMD_CLEAR = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_SEND  = 3'd3;
  localparam logic [2:0] CMD_END   = 3'd4;
  localparam logic [2:0] CMD_FILL  = 3'd5;

  localparam logic [7:0] WRITE_CMD_RST = 8'd128;
  localparam logic [7:0] CLEAR_CMD_RST = 8'd32;

  // A classified command waiting for the back end.
  typedef struct packed {
    logic [2:0]       op;
    logic [7:0]       row;
    logic [COL_W-1:0] col;
    logic [2:0]       sh;
    logic [2:0]       color;
    logic [7:0]       fill;
  } item_t;

  // One byte for the display link.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ===== hdl/cmfs_queue.sv =====
// ----------------------------------------------------------------------------
// cmfs_queue: small synchronous FIFO
// Register-based queue with a fill level; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module cmfs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_wr, do_rd;

  assign full  = (level_r == LVL_W'(DEPTH));
  assign empty = (level_r == '0);
  assign level = level_r;
  assign dout  = mem_r[rd_ptr_r];

  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r + LVL_W'(do_wr) - LVL_W'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/cmfs_front.sv =====
// ----------------------------------------------------------------------------
// cmfs_front: command classifier
// Drops commands that do nothing and works out the pixel's byte and bit offset.
// ----------------------------------------------------------------------------
module cmfs_front #(
  parameter int DISPLAY_WIDTH  = cmfs_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = cmfs_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic           in_push,
  input  logic           q_full,
  input  logic [2:0]     in_cmd,
  input  logic [7:0]     in_pos_x,
  input  logic [7:0]     in_pos_y,
  input  logic [2:0]     in_pixel_color,
  input  logic [7:0]     in_fill_byte,
  output logic           item_valid,
  output cmfs_pkg::item_t item
);

  import cmfs_pkg::*;

  logic [8:0] bit_pos;
  logic       x_ok, y_ok, useful;

  // Bit position 3x of the pixel within its line.
  assign bit_pos = {1'b0, in_pos_x} + {in_pos_x, 1'b0};
  assign x_ok    = ({1'b0, in_pos_x} < 9'(DISPLAY_WIDTH));
  assign y_ok    = ({1'b0, in_pos_y} < 9'(DISPLAY_HEIGHT));

  always_comb begin
    case (in_cmd) inside
      CMD_DRAW:                    useful = x_ok && y_ok;
      CMD_SEND, CMD_FILL:          useful = y_ok;
      CMD_CLEAR, CMD_START, CMD_END: useful = 1'b1;
      default:                     useful = 1'b0;
    endcase
  end

  assign item_valid = in_push && !q_full && useful;

  always_comb begin
    item.op    = in_cmd;
    item.row   = in_pos_y;
    item.col   = COL_W'(bit_pos[8:3]);
    item.sh    = bit_pos[2:0];
    item.color = in_pixel_color;
    item.fill  = in_fill_byte;
  end

endmodule

// ===== hdl/cmfs_back.sv =====
// ----------------------------------------------------------------------------
// cmfs_back: frame store and byte sequencer
// Runs one command at a time: pixel read-modify-write or a stream of bytes.
// ----------------------------------------------------------------------------
module cmfs_back #(
  parameter int DISPLAY_WIDTH  = cmfs_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = cmfs_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  cmfs_pkg::item_t                           item,
  input  logic                                      q_empty,
  output logic                                      q_pop,
  input  logic [$clog2(cmfs_pkg::OUTQ_DEPTH+1)-1:0] out_level,
  input  logic [7:0]                                write_cmd,
  input  logic [7:0]                                clear_cmd,
  output logic                                      res_valid,
  output cmfs_pkg::res_t                            res
);

  import cmfs_pkg::*;

  localparam int LINE_BYTES = (DISPLAY_WIDTH * 3 + 7) / 8;
  localparam int DEPTH      = LINE_BYTES * DISPLAY_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int ROW_W      = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;
  localparam int STEP_W     = $clog2(LINE_BYTES + 2);
  localparam int LVL_W      = $clog2(OUTQ_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EMIT = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_RD0  = 3'd3;
  localparam logic [2:0] S_RD1  = 3'd4;
  localparam logic [2:0] S_WR0  = 3'd5;
  localparam logic [2:0] S_WR1  = 3'd6;

  logic [7:0]               mem [DEPTH];
  logic [7:0]               rdata_r;

  logic [2:0]               state_r, state_nxt;
  logic [2:0]               op_r, op_nxt;
  logic [7:0]               row_r, row_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [2:0]               sh_r, sh_nxt;
  logic [2:0]               color_r, color_nxt;
  logic [7:0]               fill_r, fill_nxt;
  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [STEP_W-1:0]        last_step_r, last_step_nxt;
  logic                     row_ok_r, row_ok_nxt;
  logic [7:0]               bg_r, bg_nxt;
  logic [DISPLAY_HEIGHT-1:0] row_valid_r, row_valid_nxt;
  logic [7:0]               old0_r, old0_nxt;
  logic [7:0]               new1_r, new1_nxt;
  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_mem_r, s1_mem_nxt;
  logic [7:0]               s1_data_r, s1_data_nxt;
  logic                     s1_last_r, s1_last_nxt;

  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [7:0]               wdata;
  logic                     spill, credit, at_last;
  logic [ADDR_W-1:0]        byte_addr, step_addr;
  logic [15:0]              word, merged;

  assign spill     = (sh_r > 3'd5);
  assign byte_addr = base_r + ADDR_W'(col_r);
  assign step_addr = base_r + ADDR_W'(step_r);
  assign at_last   = (step_r == last_step_r);
  // A byte may enter the result stage only if the output queue has room for it
  // and for the byte already in flight.
  assign credit    = (out_level + LVL_W'(s1_valid_r)) < LVL_W'(OUTQ_DEPTH);

  assign word   = {spill ? rdata_r : 8'h00, old0_r};
  assign merged = (word & ~(16'h0007 << sh_r)) | ({13'b0, color_r} << sh_r);

  assign res_valid = s1_valid_r;
  assign res.data  = s1_mem_r ? (row_ok_r ? rdata_r : bg_r) : s1_data_r;
  assign res.last  = s1_last_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sh_nxt        = sh_r;
    color_nxt     = color_r;
    fill_nxt      = fill_r;
    base_nxt      = base_r;
    step_nxt      = step_r;
    last_step_nxt = last_step_r;
    row_ok_nxt    = row_ok_r;
    bg_nxt        = bg_r;
    row_valid_nxt = row_valid_r;
    old0_nxt      = old0_r;
    new1_nxt      = new1_r;
    s1_valid_nxt  = 1'b0;
    s1_mem_nxt    = s1_mem_r;
    s1_data_nxt   = s1_data_r;
    s1_last_nxt   = s1_last_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = byte_addr;
    raddr         = byte_addr;
    wdata         = bg_r;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          op_nxt     = item.op;
          row_nxt    = item.row;
          col_nxt    = item.col;
          sh_nxt     = item.sh;
          color_nxt  = item.color;
          fill_nxt   = item.fill;
          base_nxt   = ADDR_W'(item.row * LINE_BYTES);
          step_nxt   = '0;
          row_ok_nxt = row_valid_r[item.row[ROW_W-1:0]];
          case (item.op)
            CMD_DRAW: begin
              state_nxt = row_valid_r[item.row[ROW_W-1:0]] ? S_RD0 : S_INIT;
            end
            CMD_CLEAR: begin
              bg_nxt        = 8'hFF;
              row_valid_nxt = '0;
              last_step_nxt = STEP_W'(1);
              state_nxt     = S_EMIT;
            end
            CMD_START, CMD_END: begin
              last_step_nxt = '0;
              state_nxt     = S_EMIT;
            end
            CMD_SEND, CMD_FILL: begin
              last_step_nxt = STEP_W'(LINE_BYTES + 1);
              state_nxt     = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (credit) begin
          s1_valid_nxt = 1'b1;
          s1_last_nxt  = at_last;
          s1_mem_nxt   = 1'b0;
          s1_data_nxt  = 8'h00;
          case (op_r)
            CMD_CLEAR: s1_data_nxt = (step_r == '0) ? clear_cmd : 8'h00;
            CMD_START: s1_data_nxt = write_cmd;
            CMD_SEND, CMD_FILL: begin
              if (step_r == '0) begin
                s1_data_nxt = row_r + 8'd1;
              end else if (!at_last) begin
                if (op_r == CMD_SEND) begin
                  s1_mem_nxt = 1'b1;
                  mem_re     = 1'b1;
                  raddr      = step_addr - ADDR_W'(1);
                end else begin
                  s1_data_nxt = fill_r;
                end
              end
            end
            default: s1_data_nxt = 8'h00;
          endcase
          step_nxt = step_r + STEP_W'(1);
          if (at_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_INIT: begin
        // First touch of a row since reset or clear: write the background first.
        mem_we   = 1'b1;
        waddr    = step_addr;
        wdata    = bg_r;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(LINE_BYTES - 1)) begin
          row_valid_nxt[row_r[ROW_W-1:0]] = 1'b1;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        mem_re    = 1'b1;
        raddr     = byte_addr;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        mem_re    = spill;
        raddr     = byte_addr + ADDR_W'(1);
        old0_nxt  = rdata_r;
        state_nxt = S_WR0;
      end
      S_WR0: begin
        mem_we    = 1'b1;
        waddr     = byte_addr;
        wdata     = merged[7:0];
        new1_nxt  = merged[15:8];
        state_nxt = spill ? S_WR1 : S_IDLE;
      end
      S_WR1: begin
        mem_we    = 1'b1;
        waddr     = byte_addr + ADDR_W'(1);
        wdata     = new1_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      s1_valid_r  <= 1'b0;
      bg_r        <= 8'h00;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      bg_r        <= bg_nxt;
      row_valid_r <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    sh_r        <= sh_nxt;
    color_r     <= color_nxt;
    fill_r      <= fill_nxt;
    base_r      <= base_nxt;
    step_r      <= step_nxt;
    last_step_r <= last_step_nxt;
    row_ok_r    <= row_ok_nxt;
    old0_r      <= old0_nxt;
    new1_r      <= new1_nxt;
    s1_mem_r    <= s1_mem_nxt;
    s1_data_r   <= s1_data_nxt;
    s1_last_r   <= s1_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hdl/color_memory_lcd_frame_serializer_top.sv =====
// ----------------------------------------------------------------------------
// color_memory_lcd_frame_serializer_top: 3-bit color memory LCD frame buffer
// Accepts drawing and line commands and produces the byte stream for the panel.
// ----------------------------------------------------------------------------
// Throughput: a pixel draw is a read-modify-write in the store sequencer, with a
//   second byte read and written when the color straddles two bytes, after a
//   background fill of the row the first time it is drawn after reset or clear.
//   A line command gives one output byte per cycle while the output queue has
//   room, bounded by the single store read port and the pop rate.
// Reset: rst_n is synchronous, active low; the store reads as all zeros at once.
// ----------------------------------------------------------------------------
module color_memory_lcd_frame_serializer_top #(
  parameter int DISPLAY_WIDTH  = cmfs_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = cmfs_pkg::DISPLAY_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Command input, queue style.
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [2:0]                   in_cmd,
  input  logic [7:0]                   in_pos_x,
  input  logic [7:0]                   in_pos_y,
  input  logic [2:0]                   in_pixel_color,
  input  logic [7:0]                   in_fill_byte,
  // Byte output, queue style.
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  // Register writes.
  input  logic                         cfg_we,
  input  logic [cmfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_wdata
);

  import cmfs_pkg::*;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);
  localparam int LVL_W  = $clog2(OUTQ_DEPTH + 1);

  // Mode bytes sent at frame start and on clear.
  logic [7:0] write_cmd_r, write_cmd_nxt;
  logic [7:0] clear_cmd_r, clear_cmd_nxt;

  logic              item_valid;
  item_t             item_in, item_out;
  logic [ITEM_W-1:0] item_q;
  logic              cmdq_full, cmdq_empty, cmdq_pop;
  logic [$clog2(CMDQ_DEPTH+1)-1:0] cmdq_level;

  logic              res_valid;
  res_t              res_in, res_out;
  logic [RES_W-1:0]  res_q;
  logic              outq_full;
  logic [LVL_W-1:0]  outq_level;

  always_comb begin
    write_cmd_nxt = write_cmd_r;
    clear_cmd_nxt = clear_cmd_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WRITE_CMD: write_cmd_nxt = cfg_wdata;
        CFG_CLEAR_CMD: clear_cmd_nxt = cfg_wdata;
        default: begin
          write_cmd_nxt = write_cmd_r;
          clear_cmd_nxt = clear_cmd_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_cmd_r <= WRITE_CMD_RST;
      clear_cmd_r <= CLEAR_CMD_RST;
    end else begin
      write_cmd_r <= write_cmd_nxt;
      clear_cmd_r <= clear_cmd_nxt;
    end
  end

  // The front end filters out commands that produce nothing (off-panel draws
  // and lines, unused codes), so every queued item does real work.
  cmfs_front #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_front (
    .in_push        (in_push),
    .q_full         (cmdq_full),
    .in_cmd         (in_cmd),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pixel_color (in_pixel_color),
    .in_fill_byte   (in_fill_byte),
    .item_valid     (item_valid),
    .item           (item_in)
  );

  // The command queue decouples input transfers from the store sequencer, so
  // a burst of draws is taken one per cycle until the queue fills.
  assign in_full = cmdq_full;

  cmfs_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (item_valid),
    .din   (item_in),
    .full  (cmdq_full),
    .rd_en (cmdq_pop),
    .dout  (item_q),
    .empty (cmdq_empty),
    .level (cmdq_level)
  );

  assign item_out = item_t'(item_q);

  // The sequencer owns the frame store. Rows untouched since reset or clear are
  // tracked by one valid bit each and read as the current background value.
  cmfs_back #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item_out),
    .q_empty   (cmdq_empty),
    .q_pop     (cmdq_pop),
    .out_level (outq_level),
    .write_cmd (write_cmd_r),
    .clear_cmd (clear_cmd_r),
    .res_valid (res_valid),
    .res       (res_in)
  );

  // The output queue holds finished bytes; the sequencer only issues a byte
  // when there is room, so no transfer into this queue is ever refused.
  cmfs_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (res_valid),
    .din   (res_in),
    .full  (outq_full),
    .rd_en (out_pop),
    .dout  (res_q),
    .empty (out_empty),
    .level (outq_level)
  );

  assign res_out  = res_t'(res_q);
  assign out_byte = outq_full ? res_out.data : res_out.data;
  assign out_last = res_out.last;

endmodule
